FILE: src/window_max_prob_splat_defines.svh
// Assertion macros used by the checker.
`ifndef WINDOW_MAX_PROB_SPLAT_DEFINES_SVH
`define WINDOW_MAX_PROB_SPLAT_DEFINES_SVH

// Property checked while reset is released.
`define WMPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define WMPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/wmps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wmps_pkg;

    localparam int MAX_ROWS   = 256;
    localparam int MAX_COLS   = 256;
    localparam int NUM_LABELS = 16;

    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CFG_W   = 9;
    localparam int DIM_MAX = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int SZ_W0   = $clog2(DIM_MAX + 1);
    localparam int SZ_W    = (SZ_W0 > CFG_W) ? SZ_W0 : CFG_W;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EVAL_CLASS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 2'd2;

    localparam logic REQ_SPLAT = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    localparam logic [7:0] LABEL_HIT  = 8'd255;
    localparam logic [7:0] LABEL_MISS = 8'd0;

    typedef struct packed {
        logic [15:0] best_peak;
        logic [7:0]  best_id;
        logic [15:0] eval_peak;
    } t_pix;

    typedef struct packed {
        logic signed [CFG_W-1:0] eval_class;
        logic [SZ_W-1:0]         rows_eff;
        logic [SZ_W-1:0]         cols_eff;
    } t_cfg;

    typedef struct packed {
        logic [7:0] left;
        logic [7:0] right;
        logic [7:0] top;
        logic [7:0] bottom;
    } t_win;

    typedef struct packed {
        logic              active;
        logic              last;
        logic [ADDR_W-1:0] addr;
    } t_scan;

    typedef struct packed {
        logic [7:0]  label_out;
        logic [15:0] prob_out;
        logic [7:0]  best_class;
    } t_res;

    function automatic logic [ADDR_W-1:0] pix_addr(input logic [7:0] row,
                                                   input logic [7:0] col);
        pix_addr = ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
    endfunction

endpackage

`default_nettype wire

FILE: src/wmps_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wmps_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [3:0] label_slot;
    logic [7:0] class_id;
    logic [15:0] prob;
    logic [7:0] win_left;
    logic [7:0] win_right;
    logic [7:0] win_top;
    logic [7:0] win_bottom;
    logic [7:0] pixel_row;
    logic [7:0] pixel_col;

    modport source (
        output valid, req_type, label_slot, class_id, prob,
               win_left, win_right, win_top, win_bottom, pixel_row, pixel_col,
        input  ready
    );
    modport sink (
        input  valid, req_type, label_slot, class_id, prob,
               win_left, win_right, win_top, win_bottom, pixel_row, pixel_col,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/wmps_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wmps_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  label_out;
    logic [15:0] prob_out;
    logic [7:0]  best_class;

    modport source (output valid, label_out, prob_out, best_class, input ready);
    modport sink (input valid, label_out, prob_out, best_class, output ready);
endinterface

`default_nettype wire

FILE: src/wmps_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wmps_cfg_if;
    import wmps_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/wmps_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module wmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/wmps_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module wmps_cfg_regs (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    wmps_cfg_if.sink      i_cfg,
    output wmps_pkg::t_cfg o_cfg
);
    import wmps_pkg::*;

    logic [CFG_W-1:0] r_eval_class;
    logic [CFG_W-1:0] r_image_rows;
    logic [CFG_W-1:0] r_image_cols;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eval_class <= 9'h1FF;
            r_image_rows <= 9'd256;
            r_image_cols <= 9'd256;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_EVAL_CLASS: r_eval_class <= i_cfg.data;
                CFG_IMAGE_ROWS: r_image_rows <= i_cfg.data;
                CFG_IMAGE_COLS: r_image_cols <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // clip the size registers to the store geometry
    always_comb begin
        o_cfg.eval_class = r_eval_class;
        o_cfg.rows_eff   = (SZ_W'(r_image_rows) < SZ_W'(MAX_ROWS)) ?
                           SZ_W'(r_image_rows) : SZ_W'(MAX_ROWS);
        o_cfg.cols_eff   = (SZ_W'(r_image_cols) < SZ_W'(MAX_COLS)) ?
                           SZ_W'(r_image_cols) : SZ_W'(MAX_COLS);
    end

endmodule

`default_nettype wire

FILE: src/wmps_win_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module wmps_win_scan (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire wmps_pkg::t_win i_win,
    output wmps_pkg::t_scan     o_scan
);
    import wmps_pkg::*;

    logic       r_active;
    logic [7:0] r_row;
    logic [7:0] r_col;
    logic [7:0] r_left;
    logic [7:0] r_right;
    logic [7:0] r_bottom;
    logic       end_col;
    logic       end_row;

    assign end_col = (r_col == r_right);
    assign end_row = (r_row == r_bottom);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_start) begin
            r_active <= 1'b1;
        end else if (r_active && end_col && end_row) begin
            r_active <= 1'b0;
        end
    end

    // raster walk, one pixel per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_row    <= i_win.top;
            r_col    <= i_win.left;
            r_left   <= i_win.left;
            r_right  <= i_win.right;
            r_bottom <= i_win.bottom;
        end else if (r_active) begin
            if (end_col) begin
                r_col <= r_left;
                r_row <= r_row + 8'd1;
            end else begin
                r_col <= r_col + 8'd1;
            end
        end
    end

    always_comb begin
        o_scan.active = r_active;
        o_scan.last   = r_active && end_col && end_row;
        o_scan.addr   = pix_addr(r_row, r_col);
    end

endmodule

`default_nettype wire

FILE: src/window_max_prob_splat.sv
// Splat: the clipped window is walked pixel by pixel, and the next item waits
// for the last write-back; a splat that touches no pixel starts no walk.
// Pixel rate is one read-modify-write per cycle through the single store RAM.
// Readout: the pixel is read, then cleared and its result registered for output;
// a pixel outside the image skips the store and returns an all-zero result.
// Reset: synchronous, active low; then a clearing pass over the store, no items taken.
`timescale 1ns / 1ps
`default_nettype none

module window_max_prob_splat (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wmps_req_if.sink  i_req,
    wmps_res_if.source o_res,
    wmps_cfg_if.sink  i_cfg
);
    import wmps_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR   = 5'b00001,
        S_IDLE    = 5'b00010,
        S_SPLAT   = 5'b00100,
        S_RD_DATA = 5'b01000,
        S_RD_PUSH = 5'b10000
    } t_state;

    t_state r_state, n_state;

    t_cfg  cfg;
    t_scan scan;
    t_win  win_clip;

    // clearing pass
    logic [ADDR_W-1:0] r_clr_addr;

    // splat item context, stable while the walk runs
    logic [15:0] r_prob;
    logic [7:0]  r_cls;
    logic        r_track;

    // write-back stage: data for r_wb_addr returns from the RAM this cycle
    logic              r_wb_valid;
    logic [ADDR_W-1:0] r_wb_addr;

    // readout
    logic [ADDR_W-1:0] r_rd_addr;
    t_res              r_res, n_res;
    t_res              r_out;
    logic              r_out_valid;

    // RAM ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    t_pix              ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [$bits(t_pix)-1:0] ram_rdata;
    t_pix              pix_rd;
    t_pix              pix_upd;

    logic              accept;
    logic              is_splat;
    logic [SZ_W-1:0]   last_col;
    logic [SZ_W-1:0]   last_row;
    logic              slot_ok;
    logic              splat_go;
    logic              rd_in_img;
    logic              rd_issue;
    logic              eval_on;
    logic              push;

    wmps_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    wmps_win_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (splat_go),
        .i_win   (win_clip),
        .o_scan  (scan)
    );

    wmps_ram #(
        .WIDTH ($bits(t_pix)),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Hold off the next item until the last pixel write of a splat has landed,
    // so a new read never races a pending write to the same pixel.
    assign i_req.ready = (r_state == S_IDLE) && !r_wb_valid;
    assign accept      = i_req.valid && i_req.ready;
    assign is_splat    = (i_req.req_type == REQ_SPLAT);
    assign eval_on     = !cfg.eval_class[CFG_W-1];

    // Window clipping: right and bottom pulled in to the last column and row.
    // Empty or out-of-image windows (and slots past the label list) start no walk.
    always_comb begin
        last_col        = cfg.cols_eff - SZ_W'(1);
        last_row        = cfg.rows_eff - SZ_W'(1);
        win_clip.left   = i_req.win_left;
        win_clip.top    = i_req.win_top;
        win_clip.right  = (SZ_W'(i_req.win_right) > last_col) ?
                          last_col[7:0] : i_req.win_right;
        win_clip.bottom = (SZ_W'(i_req.win_bottom) > last_row) ?
                          last_row[7:0] : i_req.win_bottom;
        slot_ok         = (9'(i_req.label_slot) < 9'(NUM_LABELS));
        splat_go        = accept && is_splat && slot_ok &&
                          (cfg.rows_eff != '0) && (cfg.cols_eff != '0) &&
                          (win_clip.left <= win_clip.right) &&
                          (win_clip.top <= win_clip.bottom);
        rd_in_img       = (SZ_W'(i_req.pixel_row) < cfg.rows_eff) &&
                          (SZ_W'(i_req.pixel_col) < cfg.cols_eff);
        rd_issue        = accept && !is_splat && rd_in_img;
    end

    // read port: walker addresses during a splat, else the readout pixel
    assign ram_re    = scan.active || rd_issue;
    assign ram_raddr = scan.active ? scan.addr :
                       pix_addr(i_req.pixel_row, i_req.pixel_col);
    assign pix_rd    = t_pix'(ram_rdata);

    // modify: strictly larger wins, so ties keep the earlier splat
    always_comb begin
        pix_upd = pix_rd;
        if (pix_rd.best_peak < r_prob) begin
            pix_upd.best_peak = r_prob;
            pix_upd.best_id   = r_cls;
        end
        if (r_track && (pix_rd.eval_peak < r_prob)) begin
            pix_upd.eval_peak = r_prob;
        end
    end

    // write port: clearing pass, splat write-back, or readout clear
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wb_addr;
        ram_wdata = pix_upd;
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (r_wb_valid) begin
            ram_we    = 1'b1;
        end else if (r_state == S_RD_DATA) begin
            ram_we    = 1'b1;
            ram_waddr = r_rd_addr;
            ram_wdata = '0;
        end
    end

    // readout result: the label hits only when reporting is on and classes match
    always_comb begin
        n_res = r_res;
        if (accept && !is_splat && !rd_in_img) begin
            n_res = '0;
        end else if (r_state == S_RD_DATA) begin
            n_res.best_class = pix_rd.best_id;
            if (eval_on && (pix_rd.best_id == cfg.eval_class[7:0])) begin
                n_res.label_out = LABEL_HIT;
                n_res.prob_out  = pix_rd.eval_peak;
            end else begin
                n_res.label_out = LABEL_MISS;
                n_res.prob_out  = 16'd0;
            end
        end
    end

    assign push = (r_state == S_RD_PUSH) && (!r_out_valid || o_res.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (splat_go) begin
                    n_state = S_SPLAT;
                end else if (rd_issue) begin
                    n_state = S_RD_DATA;
                end else if (accept && !is_splat) begin
                    n_state = S_RD_PUSH;
                end
            end
            S_SPLAT: begin
                if (scan.last) n_state = S_IDLE;
            end
            S_RD_DATA: n_state = S_RD_PUSH;
            S_RD_PUSH: begin
                if (push) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wb_valid <= scan.active;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_addr <= scan.addr;
        r_res     <= n_res;
        if (splat_go) begin
            r_prob  <= i_req.prob;
            r_cls   <= i_req.class_id;
            r_track <= eval_on &&
                       (cfg.eval_class[7:0] == 8'(i_req.label_slot));
        end
        if (rd_issue) begin
            r_rd_addr <= ram_raddr;
        end
        if (push) begin
            r_out <= r_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.label_out  = r_out.label_out;
    assign o_res.prob_out   = r_out.prob_out;
    assign o_res.best_class = r_out.best_class;

endmodule

`default_nettype wire

FILE: src/wmps_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "window_max_prob_splat_defines.svh"

module wmps_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [7:0]  i_label,
    input wire logic [15:0] i_prob
);
    import wmps_pkg::*;

    `WMPS_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped while stalled")
    `WMPS_ASSERT(a_label_code, i_clk, i_rst_n, i_out_valid |-> (i_label == LABEL_HIT || i_label == LABEL_MISS), "bad label code")
    `WMPS_ASSERT(a_miss_zero, i_clk, i_rst_n, i_out_valid && i_label == LABEL_MISS |-> i_prob == 16'd0, "probability without label hit")
    `WMPS_ASSERT_ALWAYS(a_clear_busy, i_clk, $rose(i_rst_n) |-> !i_in_ready, "item taken during clearing pass")

endmodule

bind window_max_prob_splat wmps_checker u_wmps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_label     (o_res.label_out),
    .i_prob      (o_res.prob_out)
);

`default_nettype wire
